### sv/vlie_pkg.sv
// Shared types and constants for the versioned log index engine.
// No dependencies; every other file imports this package.
package vlie_pkg;

	localparam int REQ_W    = 2;
	localparam int ID_W     = 12;
	localparam int SIZE_W   = 32;
	localparam int REV_W    = 16;
	localparam int OFS_W    = 48;
	localparam int CNT_W    = 13;
	localparam int STAT_W   = 3;
	localparam int ENTRY_W  = REV_W + OFS_W;
	localparam int INC_W    = SIZE_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = OFS_W;

	localparam logic [INC_W-1:0]   HEADER_BYTES  = INC_W'(8);
	localparam logic [ENTRY_W-1:0] DELETED_ENTRY = '1;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_PUT    = 2'd1,
		REQ_GET    = 2'd2,
		REQ_REMOVE = 2'd3
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_CONFLICT  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOG_BASE  = 2'd0,
		CFG_IDS_START = 2'd1
	} cfg_index_t;

endpackage

### sv/vlie_if.sv
// Handshake channels of the versioned log index engine: request, response
// and configuration write. Depends on vlie_pkg.
interface vlie_req_if import vlie_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [ID_W-1:0]   entry_id;
	logic [SIZE_W-1:0] record_bytes;
	logic [REV_W-1:0]  expected_revision;

	modport source (output valid, req_type, entry_id, record_bytes, expected_revision,
		input ready);
	modport sink (input valid, req_type, entry_id, record_bytes, expected_revision,
		output ready);
endinterface

interface vlie_rsp_if import vlie_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   given_id;
	logic [OFS_W-1:0]  record_offset;
	logic [REV_W-1:0]  record_revision;

	modport source (output valid, status, given_id, record_offset, record_revision,
		input ready);
	modport sink (input valid, status, given_id, record_offset, record_revision,
		output ready);
endinterface

interface vlie_cfg_if import vlie_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/vlie_table.sv
// Index table memory: one synchronous read port, one write port, and a
// clearing sweep after reset. Depends on vlie_pkg.
module vlie_table import vlie_pkg::*; #(
	parameter int ENTRIES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output logic [ENTRY_W-1:0]         rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  logic [ENTRY_W-1:0]         wr_data,
	output logic                       clearing
);

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

	logic [ENTRY_W-1:0] mem [ENTRIES];
	logic [AW-1:0]      clr_addr_q;
	logic               clearing_q;

	// Sweep every entry to zero once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Write port: the sweep owns it while clearing
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clearing_q;

endmodule

### sv/versioned_log_index_engine_unit.sv
// Top level of the versioned log index engine: request decode, entry
// read-modify-write and the response register. Depends on vlie_pkg,
// vlie_if and vlie_table.
//
//  channel | role  | transfer moves
//  --------+-------+-------------------------------------------------------
//  req     | sink  | req_type, entry_id, record_bytes, expected_revision
//  rsp     | source| status, given_id, record_offset, record_revision
//  cfg     | sink  | index (0 log_base_offset, 1 ids_in_use_at_start), data
//
// Each request passes through S_IDLE and S_EXEC: the transfer in S_IDLE issues the
// table read, and S_EXEC checks the entry, writes it back and loads the response.
// After reset the table sweeps all ENTRIES entries to zero (4096 by
// default); req.ready stays low during the sweep, cfg is taken at all times.
// A response waiting on rsp.ready holds the engine in S_EXEC.
module versioned_log_index_engine_unit import vlie_pkg::*; #(
	parameter int ENTRIES = 4096
) (
	input  logic   clk,
	input  logic   arst_n,
	vlie_req_if.sink   req,
	vlie_rsp_if.source rsp,
	vlie_cfg_if.sink   cfg
);

	localparam int AW = $clog2(ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [OFS_W-1:0] log_base_q;
	logic [CNT_W-1:0] ids_start_q;
	logic [OFS_W-1:0] bytes_q;
	logic [CNT_W-1:0] ids_alloc_q;

	// request latched at transfer
	req_type_t        type_s1;
	logic [AW-1:0]    addr_s1;
	logic             bad_id_s1;
	logic             zero_size_s1;
	logic [REV_W-1:0] exp_rev_s1;
	logic [OFS_W-1:0] tail_s1;
	logic [INC_W-1:0] inc_s1;
	logic             full_s1;
	logic [ID_W-1:0]  next_id_s1;

	// response register
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]   given_id_q;
	logic [OFS_W-1:0]  offset_q;
	logic [REV_W-1:0]  revision_q;

	// response under construction
	logic [STAT_W-1:0] next_status;
	logic [ID_W-1:0]   next_given_id;
	logic [OFS_W-1:0]  next_offset;
	logic [REV_W-1:0]  next_revision;

	logic               clearing;
	logic               in_xfer;
	logic               load;
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [ENTRY_W-1:0] wr_data;
	logic [REV_W-1:0]   cur_rev;
	logic [REV_W-1:0]   new_rev;
	logic [CNT_W:0]     next_id;
	logic               id_out_of_range;

	assign req.ready = (state_q == S_IDLE) && !clearing;
	assign in_xfer   = req.valid && req.ready;
	assign load      = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;

	assign next_id         = {1'b0, ids_start_q} + {1'b0, ids_alloc_q};
	assign id_out_of_range = 32'(req.entry_id) >= ENTRIES;
	assign cur_rev         = rd_data[ENTRY_W-1:OFS_W];
	assign new_rev         = exp_rev_s1 + REV_W'(1);

	vlie_table #(.ENTRIES(ENTRIES)) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_xfer && !id_out_of_range),
		.rd_addr  (AW'(req.entry_id)),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (addr_s1),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_base_q  <= '0;
			ids_start_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_LOG_BASE:  log_base_q  <= cfg.data;
				CFG_IDS_START: ids_start_q <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Latch the request and precompute tail, increment and allocation bound
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			type_s1      <= req_type_t'(req.req_type);
			addr_s1      <= AW'(req.entry_id);
			bad_id_s1    <= id_out_of_range;
			zero_size_s1 <= (req.record_bytes == '0);
			exp_rev_s1   <= req.expected_revision;
			tail_s1      <= log_base_q + bytes_q;
			inc_s1       <= HEADER_BYTES +
				((req.req_type == REQ_PUT) ? INC_W'(req.record_bytes) : '0);
			full_s1      <= 32'(next_id) >= ENTRIES;
			next_id_s1   <= next_id[ID_W-1:0];
		end
	end

	// Entry write-back
	always_comb begin
		wr_en   = 1'b0;
		wr_data = DELETED_ENTRY;
		if (load && !bad_id_s1) begin
			case (type_s1)
				REQ_PUT: begin
					wr_en   = !zero_size_s1 && (cur_rev == exp_rev_s1);
					wr_data = {new_rev, tail_s1};
				end
				REQ_REMOVE: wr_en = 1'b1;
				default: ;
			endcase
		end
	end

	// Sequence S_IDLE and S_EXEC and advance the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bytes_q     <= '0;
			ids_alloc_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (load) begin
						state_q <= S_IDLE;
						if (type_s1 == REQ_ALLOC && !full_s1) begin
							ids_alloc_q <= ids_alloc_q + CNT_W'(1);
						end
						if (wr_en) begin
							bytes_q <= bytes_q + OFS_W'(inc_s1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Build the response for the entry under processing
	always_comb begin
		next_status   = ST_OK;
		next_given_id = '0;
		next_offset   = '0;
		next_revision = '0;
		if (type_s1 == REQ_ALLOC) begin
			if (full_s1) begin
				next_status = ST_FULL;
			end else begin
				next_given_id = next_id_s1;
			end
		end else if (bad_id_s1) begin
			next_status = ST_INVALID;
		end else begin
			case (type_s1)
				REQ_PUT: begin
					if (zero_size_s1) begin
						next_status = ST_INVALID;
					end else if (cur_rev != exp_rev_s1) begin
						next_status   = ST_CONFLICT;
						next_revision = cur_rev;
					end else begin
						next_offset   = tail_s1;
						next_revision = new_rev;
					end
				end
				REQ_GET: begin
					if (rd_data == DELETED_ENTRY) begin
						next_status = ST_NOT_FOUND;
					end else begin
						next_offset   = rd_data[OFS_W-1:0];
						next_revision = cur_rev;
					end
				end
				default: ;
			endcase
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (load) begin
			status_q   <= next_status;
			given_id_q <= next_given_id;
			offset_q   <= next_offset;
			revision_q <= next_revision;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = status_q;
	assign rsp.given_id        = given_id_q;
	assign rsp.record_offset   = offset_q;
	assign rsp.record_revision = revision_q;

	// Checks on the sequencing
	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready)
		else $error("request taken during table sweep");

	a_xfer_enters_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_EXEC))
		else $error("transfer did not start entry processing");

	a_write_only_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_EXEC) && !clearing)
		else $error("table write outside entry processing");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EXEC))
		else $error("response raised without entry processing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || rsp.ready))
		else $error("pending response overwritten");

endmodule
